>>> rtl/kmhq_pkg.sv
// Package for the k-ary max-heap queue: widths, request and status codes,
// controller states, datapath commands and the status word.
// Depends on nothing; the controller, datapath, top level and bench use it.
`default_nettype none
package kmhq_pkg;
	localparam int CAPACITY  = 1024;
	localparam int MAX_ARITY = 8;
	localparam int KEY_W     = 32;
	localparam int ADDR_W    = 10;
	localparam int CNT_W     = 11;
	localparam int ARITY_W   = 4;
	localparam int CH_W      = 14;
	localparam int RECIP_W   = 16;

	localparam logic [2:0] REQ_INSERT  = 3'd0;
	localparam logic [2:0] REQ_EXTRACT = 3'd1;
	localparam logic [2:0] REQ_CHANGE  = 3'd2;
	localparam logic [2:0] REQ_APPEND  = 3'd3;
	localparam logic [2:0] REQ_BUILD   = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_BADIX = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_EX_B, S_EX_C, S_CH_B, S_UP_RD, S_UP_CMP,
		S_DN_RD, S_DN_CMP, S_BLD_NEXT, S_BLD_LD, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_START, OP_DISP, OP_EX_B, OP_EX_C, OP_UP_RD, OP_UP_CMP,
		OP_DN_RD, OP_DN_CMP, OP_BLD_NEXT, OP_BLD_LD, OP_DONE
	} op_t;

	typedef struct packed {
		logic [2:0] req;
		logic       full;
		logic       empty;
		logic       idx_bad;
		logic       pos_zero;
		logic       up_swap;
		logic       ch_ok;
		logic       dn_move;
		logic       key_gt;
		logic       key_lt;
		logic       bld;
		logic       bi_zero;
		logic       out_busy;
	} sts_t;

	// Reciprocal of the arity scaled by 2**16 and rounded up; exact for
	// quotients of 10-bit values.
	function automatic logic [RECIP_W-1:0] recip(input logic [ARITY_W-1:0] k);
		logic [RECIP_W-1:0] r;
		case (k)
			4'd3:    r = 16'd21846;
			4'd4:    r = 16'd16384;
			4'd5:    r = 16'd13108;
			4'd6:    r = 16'd10923;
			4'd7:    r = 16'd9363;
			4'd8:    r = 16'd8192;
			default: r = 16'd32768;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

>>> rtl/kmhq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none
module kmhq_ram #(
	parameter int W = 32,
	parameter int D = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/kmhq_ctrl.sv
// Controller state machine of the heap queue: sequences the datapath.
// Depends on kmhq_pkg.
`default_nettype none
module kmhq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	input  wire kmhq_pkg::sts_t sts,
	output logic                req_stall,
	output kmhq_pkg::op_t       op
);
	kmhq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kmhq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			kmhq_pkg::S_IDLE: begin
				if (req_valid) state_d = kmhq_pkg::S_DISP;
			end
			kmhq_pkg::S_DISP: begin
				case (sts.req)
					kmhq_pkg::REQ_INSERT:
						state_d = sts.full ? kmhq_pkg::S_DONE : kmhq_pkg::S_UP_RD;
					kmhq_pkg::REQ_EXTRACT:
						state_d = sts.empty ? kmhq_pkg::S_DONE : kmhq_pkg::S_EX_B;
					kmhq_pkg::REQ_CHANGE:
						state_d = sts.idx_bad ? kmhq_pkg::S_DONE : kmhq_pkg::S_CH_B;
					kmhq_pkg::REQ_BUILD:
						state_d = sts.empty ? kmhq_pkg::S_DONE : kmhq_pkg::S_BLD_NEXT;
					default: state_d = kmhq_pkg::S_DONE;
				endcase
			end
			kmhq_pkg::S_EX_B: state_d = kmhq_pkg::S_EX_C;
			kmhq_pkg::S_EX_C:
				state_d = sts.empty ? kmhq_pkg::S_DONE : kmhq_pkg::S_DN_RD;
			kmhq_pkg::S_CH_B: begin
				if (sts.key_gt) state_d = kmhq_pkg::S_UP_RD;
				else if (sts.key_lt) state_d = kmhq_pkg::S_DN_RD;
				else state_d = kmhq_pkg::S_DONE;
			end
			kmhq_pkg::S_UP_RD:
				state_d = sts.pos_zero ? kmhq_pkg::S_DONE : kmhq_pkg::S_UP_CMP;
			kmhq_pkg::S_UP_CMP:
				state_d = sts.up_swap ? kmhq_pkg::S_UP_RD : kmhq_pkg::S_DONE;
			kmhq_pkg::S_DN_RD: begin
				if (sts.ch_ok) state_d = kmhq_pkg::S_DN_CMP;
				else if (sts.dn_move) state_d = kmhq_pkg::S_DN_RD;
				else if (sts.bld) state_d = kmhq_pkg::S_BLD_NEXT;
				else state_d = kmhq_pkg::S_DONE;
			end
			kmhq_pkg::S_DN_CMP: state_d = kmhq_pkg::S_DN_RD;
			kmhq_pkg::S_BLD_NEXT:
				state_d = sts.bi_zero ? kmhq_pkg::S_DONE : kmhq_pkg::S_BLD_LD;
			kmhq_pkg::S_BLD_LD: state_d = kmhq_pkg::S_DN_RD;
			kmhq_pkg::S_DONE: begin
				if (!sts.out_busy) state_d = kmhq_pkg::S_IDLE;
			end
			default: state_d = kmhq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		op = kmhq_pkg::OP_NONE;
		case (state_q)
			kmhq_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) op = kmhq_pkg::OP_START;
			end
			kmhq_pkg::S_DISP:     op = kmhq_pkg::OP_DISP;
			kmhq_pkg::S_EX_B:     op = kmhq_pkg::OP_EX_B;
			kmhq_pkg::S_EX_C:     op = kmhq_pkg::OP_EX_C;
			kmhq_pkg::S_CH_B:     op = kmhq_pkg::OP_NONE;
			kmhq_pkg::S_UP_RD:    op = kmhq_pkg::OP_UP_RD;
			kmhq_pkg::S_UP_CMP:   op = kmhq_pkg::OP_UP_CMP;
			kmhq_pkg::S_DN_RD:    op = kmhq_pkg::OP_DN_RD;
			kmhq_pkg::S_DN_CMP:   op = kmhq_pkg::OP_DN_CMP;
			kmhq_pkg::S_BLD_NEXT: op = kmhq_pkg::OP_BLD_NEXT;
			kmhq_pkg::S_BLD_LD:   op = kmhq_pkg::OP_BLD_LD;
			kmhq_pkg::S_DONE: begin
				if (!sts.out_busy) op = kmhq_pkg::OP_DONE;
			end
			default: op = kmhq_pkg::OP_NONE;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/kmhq_dpath.sv
// Datapath of the heap queue: request and walk registers, the heap RAM,
// parent and child index arithmetic and the result register.
// Depends on kmhq_pkg and kmhq_ram.
`default_nettype none
module kmhq_dpath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire kmhq_pkg::op_t                     op,
	input  wire logic [kmhq_pkg::ARITY_W-1:0]      arity,
	input  wire logic [2:0]                        req_type,
	input  wire logic signed [kmhq_pkg::KEY_W-1:0] key_value,
	input  wire logic [kmhq_pkg::ADDR_W-1:0]       entry_index,
	input  wire logic                              rsp_stall,
	output kmhq_pkg::sts_t                         sts,
	output logic                                   rsp_valid,
	output logic signed [kmhq_pkg::KEY_W-1:0]      max_value,
	output logic [1:0]                             status,
	output logic [kmhq_pkg::CNT_W-1:0]             entry_count
);
	localparam int AW = kmhq_pkg::ADDR_W;
	localparam int CW = kmhq_pkg::CNT_W;
	localparam int KW = kmhq_pkg::KEY_W;
	localparam int RW = kmhq_pkg::RECIP_W;

	logic [2:0]              req_q;
	logic signed [KW-1:0]    key_q, cur_q, mx_q, maxv_q;
	logic [AW-1:0]           idx_q, pos_q, best_q, par_q, chq_q, bi_q;
	logic [CW-1:0]           count_q;
	logic [kmhq_pkg::ARITY_W-1:0] c_q, k;
	logic [1:0]              stat_q;
	logic                    bld_q, out_valid_q;

	logic                    we;
	logic [AW-1:0]           waddr, raddr;
	logic signed [KW-1:0]    wdata, rdata;
	logic [RW-1:0]           rk;
	logic [AW+RW-1:0]        par_prod, bi_prod;
	logic [AW-1:0]           par, pos_m1, cnt_m1, bi_init;
	logic [kmhq_pkg::CH_W-1:0] ch;

	always_comb begin
		if (arity < 4'd2) k = 4'd2;
		else if (arity > 4'(kmhq_pkg::MAX_ARITY)) k = 4'(kmhq_pkg::MAX_ARITY);
		else k = arity;
	end

	assign rk       = kmhq_pkg::recip(k);
	assign pos_m1   = pos_q - AW'(1);
	assign cnt_m1   = count_q[AW-1:0] - AW'(1);
	assign par_prod = AW'(pos_m1) * rk;
	assign bi_prod  = AW'(cnt_m1) * rk;
	assign par      = par_prod[AW+RW-1:RW];
	assign bi_init  = bi_prod[AW+RW-1:RW] + AW'(1);
	assign ch       = (kmhq_pkg::CH_W)'(k) * (kmhq_pkg::CH_W)'(pos_q)
	                  + (kmhq_pkg::CH_W)'(c_q);

	always_comb begin
		sts.req      = req_q;
		sts.full     = (count_q == CW'(kmhq_pkg::CAPACITY));
		sts.empty    = (count_q == '0);
		sts.idx_bad  = ({1'b0, idx_q} >= count_q);
		sts.pos_zero = (pos_q == '0);
		sts.up_swap  = (cur_q > rdata);
		sts.ch_ok    = (c_q <= k) && ({1'b0, ch} < (kmhq_pkg::CH_W+1)'(count_q));
		sts.dn_move  = (best_q != pos_q);
		sts.key_gt   = (key_q > rdata);
		sts.key_lt   = (rdata > key_q);
		sts.bld      = bld_q;
		sts.bi_zero  = (bi_q == '0);
		sts.out_busy = out_valid_q && rsp_stall;
	end

	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		raddr = pos_q;
		case (op)
			kmhq_pkg::OP_DISP: begin
				raddr = (req_q == kmhq_pkg::REQ_EXTRACT) ? '0 : idx_q;
				if (req_q == kmhq_pkg::REQ_APPEND && !sts.full) begin
					we = 1'b1;
					waddr = count_q[AW-1:0];
					wdata = key_q;
				end
			end
			kmhq_pkg::OP_EX_B: raddr = cnt_m1;
			kmhq_pkg::OP_UP_RD: begin
				if (sts.pos_zero) we = 1'b1;
				else raddr = par;
			end
			kmhq_pkg::OP_UP_CMP: begin
				we = 1'b1;
				wdata = sts.up_swap ? rdata : cur_q;
			end
			kmhq_pkg::OP_DN_RD: begin
				if (sts.ch_ok) begin
					raddr = ch[AW-1:0];
				end else begin
					we = 1'b1;
					wdata = sts.dn_move ? mx_q : cur_q;
				end
			end
			kmhq_pkg::OP_BLD_NEXT: raddr = bi_q - AW'(1);
			default: ;
		endcase
	end

	kmhq_ram #(.W(KW), .D(kmhq_pkg::CAPACITY)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			bld_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (op == kmhq_pkg::OP_DONE) out_valid_q <= 1'b1;
			else if (out_valid_q && !rsp_stall) out_valid_q <= 1'b0;
			case (op)
				kmhq_pkg::OP_DISP: begin
					bld_q <= (req_q == kmhq_pkg::REQ_BUILD) && !sts.empty;
					if ((req_q == kmhq_pkg::REQ_INSERT || req_q == kmhq_pkg::REQ_APPEND)
					    && !sts.full) begin
						count_q <= count_q + CW'(1);
					end
				end
				kmhq_pkg::OP_EX_B: count_q <= count_q - CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			kmhq_pkg::OP_START: begin
				req_q <= req_type;
				key_q <= key_value;
				idx_q <= entry_index;
			end
			kmhq_pkg::OP_DISP: begin
				maxv_q <= '0;
				stat_q <= kmhq_pkg::ST_OK;
				cur_q <= key_q;
				mx_q <= key_q;
				c_q <= 4'd1;
				pos_q <= idx_q;
				best_q <= idx_q;
				bi_q <= bi_init;
				case (req_q)
					kmhq_pkg::REQ_INSERT: begin
						if (sts.full) stat_q <= kmhq_pkg::ST_FULL;
						pos_q <= count_q[AW-1:0];
					end
					kmhq_pkg::REQ_APPEND: begin
						if (sts.full) stat_q <= kmhq_pkg::ST_FULL;
					end
					kmhq_pkg::REQ_EXTRACT: begin
						if (sts.empty) stat_q <= kmhq_pkg::ST_EMPTY;
					end
					kmhq_pkg::REQ_CHANGE: begin
						if (sts.idx_bad) stat_q <= kmhq_pkg::ST_BADIX;
					end
					default: ;
				endcase
			end
			kmhq_pkg::OP_EX_B: maxv_q <= rdata;
			kmhq_pkg::OP_EX_C: begin
				cur_q <= rdata;
				mx_q <= rdata;
				pos_q <= '0;
				best_q <= '0;
				c_q <= 4'd1;
			end
			kmhq_pkg::OP_UP_RD: par_q <= par;
			kmhq_pkg::OP_UP_CMP: begin
				if (sts.up_swap) pos_q <= par_q;
			end
			kmhq_pkg::OP_DN_RD: begin
				if (sts.ch_ok) begin
					chq_q <= ch[AW-1:0];
				end else if (sts.dn_move) begin
					pos_q <= best_q;
					mx_q <= cur_q;
					c_q <= 4'd1;
				end
			end
			kmhq_pkg::OP_DN_CMP: begin
				if (rdata > mx_q) begin
					mx_q <= rdata;
					best_q <= chq_q;
				end
				c_q <= c_q + 4'd1;
			end
			kmhq_pkg::OP_BLD_NEXT: begin
				pos_q <= bi_q - AW'(1);
				best_q <= bi_q - AW'(1);
				bi_q <= bi_q - AW'(1);
			end
			kmhq_pkg::OP_BLD_LD: begin
				cur_q <= rdata;
				mx_q <= rdata;
				c_q <= 4'd1;
			end
			kmhq_pkg::OP_DONE: begin
				max_value <= maxv_q;
				status <= stat_q;
				entry_count <= count_q;
			end
			default: ;
		endcase
	end

	assign rsp_valid = out_valid_q;
endmodule
`default_nettype wire

>>> rtl/kary_max_heap_queue_top.sv
// Top level of the k-ary max-heap priority queue: APB arity register,
// controller and datapath. Depends on kmhq_pkg, kmhq_ctrl and kmhq_dpath.
//
//   channel  | handshake            | words
//   request  | req_valid/req_stall  | req_type, key_value, entry_index
//   response | rsp_valid/rsp_stall  | max_value, status, entry_count
//   config   | APB psel/penable     | arity at byte address 0
//
// One request at a time: accepted in idle, dispatched, then its word is posted.
// Sift up reads and compares the parent per level; sift down reads and compares each
// child, then writes once per level; extract and build first load the node to sift.
// Reset clears the entry count and the arity goes to 2; the RAM needs no clearing.
// The next request is taken while a finished word waits on a stalled response.
`default_nettype none
module kary_max_heap_queue_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [2:0]                        paddr,
	input  wire logic [31:0]                       pwdata,
	output logic      [31:0]                       prdata,
	output logic                                   pready,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic [2:0]                        req_type,
	input  wire logic signed [kmhq_pkg::KEY_W-1:0] key_value,
	input  wire logic [kmhq_pkg::ADDR_W-1:0]       entry_index,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic signed [kmhq_pkg::KEY_W-1:0]      max_value,
	output logic [1:0]                             status,
	output logic [kmhq_pkg::CNT_W-1:0]             entry_count
);
	logic [kmhq_pkg::ARITY_W-1:0] arity_q;
	kmhq_pkg::op_t  op;
	kmhq_pkg::sts_t sts;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {28'd0, arity_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arity_q <= 4'd2;
		end else if (psel && penable && pwrite && paddr == 3'd0) begin
			arity_q <= pwdata[3:0];
		end
	end

	kmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.req_stall (req_stall),
		.op        (op)
	);

	kmhq_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.arity       (arity_q),
		.req_type    (req_type),
		.key_value   (key_value),
		.entry_index (entry_index),
		.rsp_stall   (rsp_stall),
		.sts         (sts),
		.rsp_valid   (rsp_valid),
		.max_value   (max_value),
		.status      (status),
		.entry_count (entry_count)
	);
endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for the k-ary max-heap queue: an APB arity register plus
// request/response channels. A local heap model predicts every response word.
// Depends on kmhq_pkg and kary_max_heap_queue_top.
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ARITY_ADDR = 3'd0;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct {
		logic [2:0]          op;
		logic signed [31:0]  key;
		logic [9:0]          idx;
		bit                  drain;
	} heap_req_t;

	typedef struct {
		logic signed [31:0]  maxv;
		logic [1:0]          st;
		logic [10:0]         cnt;
	} heap_rsp_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic req_valid = 0;
	logic req_stall;
	logic [2:0] req_type = '0;
	logic signed [31:0] key_value = '0;
	logic [9:0] entry_index = '0;
	logic rsp_valid;
	logic rsp_stall = 0;
	logic signed [31:0] max_value;
	logic [1:0] status;
	logic [10:0] entry_count;

	kary_max_heap_queue_top uut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	heap_req_t pending_reqs[$];
	heap_rsp_t pending_rsp[$];
	logic signed [31:0] heap_keys [kmhq_pkg::CAPACITY];
	int held = 0;
	int arity_reg = 2;
	int gen_cnt = 0;
	int errors = 0;
	int words_sent = 0, words_checked = 0;
	int cycles = 0;
	bit no_idle = 0;

	function automatic int eff_arity();
		if (arity_reg < 2) return 2;
		if (arity_reg > kmhq_pkg::MAX_ARITY) return kmhq_pkg::MAX_ARITY;
		return arity_reg;
	endfunction

	function automatic void sift_down(int pos, int k, int n);
		int best, ch;
		logic signed [31:0] mx;
		forever begin
			best = pos;
			mx = heap_keys[pos];
			for (int c = 1; c <= k; c++) begin
				ch = k * pos + c;
				if (ch < n && heap_keys[ch] > mx) begin
					mx = heap_keys[ch];
					best = ch;
				end
			end
			if (best == pos) return;
			heap_keys[best] = heap_keys[pos];
			heap_keys[pos] = mx;
			pos = best;
		end
	endfunction

	function automatic void sift_up(int pos, int k);
		int par;
		logic signed [31:0] t;
		while (pos > 0) begin
			par = (pos - 1) / k;
			if (!(heap_keys[pos] > heap_keys[par])) return;
			t = heap_keys[pos];
			heap_keys[pos] = heap_keys[par];
			heap_keys[par] = t;
			pos = par;
		end
	endfunction

	function automatic heap_rsp_t apply_request(heap_req_t r);
		heap_rsp_t e;
		int k;
		k = eff_arity();
		e.maxv = '0;
		e.st = kmhq_pkg::ST_OK;
		case (r.op)
			kmhq_pkg::REQ_INSERT, kmhq_pkg::REQ_APPEND: begin
				if (held >= kmhq_pkg::CAPACITY) begin
					e.st = kmhq_pkg::ST_FULL;
				end else begin
					heap_keys[held] = r.key;
					held++;
					if (r.op == kmhq_pkg::REQ_INSERT) sift_up(held - 1, k);
				end
			end
			kmhq_pkg::REQ_EXTRACT: begin
				if (held == 0) begin
					e.st = kmhq_pkg::ST_EMPTY;
				end else begin
					e.maxv = heap_keys[0];
					held--;
					heap_keys[0] = heap_keys[held];
					if (held > 0) sift_down(0, k, held);
				end
			end
			kmhq_pkg::REQ_CHANGE: begin
				if (r.idx >= held) begin
					e.st = kmhq_pkg::ST_BADIX;
				end else if (r.key > heap_keys[r.idx]) begin
					heap_keys[r.idx] = r.key;
					sift_up(r.idx, k);
				end else if (r.key < heap_keys[r.idx]) begin
					heap_keys[r.idx] = r.key;
					sift_down(r.idx, k, held);
				end
			end
			kmhq_pkg::REQ_BUILD: begin
				if (held > 0) begin
					for (int i = (held - 1) / k; i >= 0; i--) sift_down(i, k, held);
				end
			end
			default: ;
		endcase
		e.cnt = held[10:0];
		return e;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [31:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'sh8000_0000;
		if (r == 1) return 32'sh7fff_ffff;
		if (r < 5) return $signed($urandom_range(0, 15)) - 8;
		return $urandom;
	endfunction

	function automatic void push_req(logic [2:0] op, logic signed [31:0] key,
			logic [9:0] idx, bit drain = 0);
		heap_req_t r;
		r.op = op;
		r.key = key;
		r.idx = idx;
		r.drain = drain;
		pending_reqs.push_back(r);
		if ((op == kmhq_pkg::REQ_INSERT || op == kmhq_pkg::REQ_APPEND)
				&& gen_cnt < kmhq_pkg::CAPACITY) gen_cnt++;
		if (op == kmhq_pkg::REQ_EXTRACT && gen_cnt > 0) gen_cnt--;
	endfunction

	function automatic void push_random(bit drain);
		int r;
		logic [9:0] ix;
		r = $urandom_range(0, 99);
		ix = 10'($urandom);
		if (r < 35) begin
			push_req(kmhq_pkg::REQ_INSERT, pick_key(), ix, drain);
		end else if (r < 60) begin
			push_req(kmhq_pkg::REQ_EXTRACT, pick_key(), ix, drain);
		end else if (r < 80) begin
			if (gen_cnt > 0) ix = 10'($urandom_range(0, gen_cnt - 1));
			push_req(kmhq_pkg::REQ_CHANGE, pick_key(), ix, drain);
		end else if (r < 84) begin
			if (gen_cnt < kmhq_pkg::CAPACITY)
				ix = 10'($urandom_range(gen_cnt, kmhq_pkg::CAPACITY - 1));
			push_req(kmhq_pkg::REQ_CHANGE, pick_key(), ix, drain);
		end else if (r < 92) begin
			push_req(kmhq_pkg::REQ_APPEND, pick_key(), ix, drain);
		end else if (r < 97) begin
			push_req(kmhq_pkg::REQ_BUILD, pick_key(), ix, drain);
		end else begin
			push_req(3'($urandom_range(5, 7)), pick_key(), ix, drain);
		end
	endfunction

	heap_req_t cur;
	int req_gap = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				pending_rsp.push_back(apply_request(cur));
				words_sent++;
			end
			if (!req_valid || !req_stall) begin
				if (req_gap > 0) begin
					req_gap--;
					req_valid <= 0;
				end else if (pending_reqs.size() > 0 &&
						!(pending_reqs[0].drain && pending_rsp.size() > 0)) begin
					cur = pending_reqs.pop_front();
					req_type <= cur.op;
					key_value <= cur.key;
					entry_index <= cur.idx;
					req_valid <= 1;
					req_gap = pick_gap();
				end else begin
					req_valid <= 0;
				end
			end
		end
	end

	int stall_left = 0;
	heap_rsp_t want;

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					$error("Response word with no request outstanding.");
					errors++;
				end else begin
					want = pending_rsp.pop_front();
					words_checked++;
					if (max_value !== want.maxv) begin
						$error("max_value: expected %0d, got %0d", want.maxv, max_value);
						errors++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						errors++;
					end
					if (entry_count !== want.cnt) begin
						$error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
						errors++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1;
			end else begin
				rsp_stall <= 0;
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[kary_max_heap_queue_top] ERROR");
			$finish;
		end
	end

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || req_valid || pending_rsp.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_arity(int v);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		penable <= 0;
		paddr <= ARITY_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		arity_reg = v & 15;
	endtask

	int arities[10] = '{3, 8, 0, 15, 5, 4, 7, 1, 6, 2};

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1;

		push_req(kmhq_pkg::REQ_BUILD, 0, 0);
		push_req(kmhq_pkg::REQ_EXTRACT, 0, 0);
		push_req(kmhq_pkg::REQ_CHANGE, 5, 0);
		push_req(kmhq_pkg::REQ_INSERT, 32'sh7fff_ffff, 10'h3ff);
		push_req(kmhq_pkg::REQ_INSERT, 32'sh8000_0000, 0);
		push_req(kmhq_pkg::REQ_INSERT, 0, 0);
		push_req(kmhq_pkg::REQ_INSERT, -1, 0);
		push_req(kmhq_pkg::REQ_INSERT, 5, 0);
		push_req(kmhq_pkg::REQ_APPEND, 7, 0);
		push_req(kmhq_pkg::REQ_APPEND, 7, 0);
		push_req(kmhq_pkg::REQ_CHANGE, 7, 6);
		push_req(kmhq_pkg::REQ_CHANGE, 32'sh8000_0000, 0);
		push_req(kmhq_pkg::REQ_CHANGE, 32'sh7fff_ffff, 6);
		push_req(kmhq_pkg::REQ_CHANGE, 1, 10'h3ff);
		push_req(kmhq_pkg::REQ_APPEND, 3, 0);
		push_req(kmhq_pkg::REQ_BUILD, 0, 0);
		push_req(3'd5, 1, 1);
		push_req(3'd6, 2, 2);
		push_req(3'd7, 3, 3);
		push_req(kmhq_pkg::REQ_EXTRACT, 0, 0);
		push_req(kmhq_pkg::REQ_EXTRACT, 0, 0);
		push_req(kmhq_pkg::REQ_EXTRACT, 0, 0);
		wait_idle();

		foreach (arities[p]) begin
			write_arity(arities[p]);
			no_idle = (p % 3 == 1);
			for (int n = 0; n < 65; n++) push_random(n == 30);
			if (p == 1) begin
				push_req(kmhq_pkg::REQ_CHANGE, pick_key(), 10'h3ff);
				push_req(kmhq_pkg::REQ_BUILD, 0, 0);
				for (int n = 0; n < 20; n++)
					push_req(kmhq_pkg::REQ_CHANGE, pick_key(), 10'($urandom));
				for (int n = 0; n < 20; n++) push_req(kmhq_pkg::REQ_EXTRACT, 0, 0);
			end
			wait_idle();
			if (p == 4) begin
				while (gen_cnt > 0) push_req(kmhq_pkg::REQ_EXTRACT, 0, 0);
				wait_idle();
			end
		end

		$display("Sent %0d request words and checked %0d responses over ten arity settings,",
			words_sent, words_checked);
		$display("including a drained heap, bad indexes, rebuilds and clamped arity values.");
		if (errors == 0) begin
			$display("[kary_max_heap_queue_top] OK");
		end else begin
			$display("[kary_max_heap_queue_top] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> kary_max_heap_queue_top.f
rtl/kmhq_pkg.sv
rtl/kmhq_ram.sv
rtl/kmhq_ctrl.sv
rtl/kmhq_dpath.sv
rtl/kary_max_heap_queue_top.sv
bench/testbench.sv
